FILE: rtl/rap_pkg.sv
`default_nettype none

package rap_pkg;

    localparam int unsigned WordW  = 32;
    localparam int unsigned AluW   = WordW + 1;
    localparam int unsigned RotAmt = 16;
    localparam int unsigned Rounds = 32'h20;
    localparam int unsigned CntW   = $clog2(Rounds);

    localparam logic [WordW-1:0] ZeroSeedHigh = 32'h6000_9755;
    localparam logic [WordW-1:0] ZeroSeedLow  = 32'hdead_beef;
    localparam logic [WordW-1:0] SeedMask     = 32'hbead_29ba;

    localparam logic ActReseed = 1'b0;
    localparam logic ActDraw   = 1'b1;

    typedef struct packed {
        logic [AluW-1:0] a;
        logic [AluW-1:0] b;
        logic            cin;
    } alu_req_t;

    function automatic logic [WordW-1:0] rot16(input logic [WordW-1:0] x);
        rot16 = {x[WordW-RotAmt-1:0], x[WordW-1:WordW-RotAmt]};
    endfunction

endpackage

`default_nettype wire

FILE: rtl/rap_alu.sv
`default_nettype none

module rap_alu
    import rap_pkg::*;
(
    input  wire alu_req_t        req,
    output logic [AluW:0]        sum
);

    assign sum = {1'b0, req.a} + {1'b0, req.b} + {{AluW{1'b0}}, req.cin};

endmodule

`default_nettype wire

FILE: rtl/rotate_add_prng_with_seeding_unit.sv
`default_nettype none

// Rotate-add generator over a pair of 32-bit words. A reseed word (action 0)
// loads the pair from s_seed_value (fixed constants for a zero seed) and
// runs 32 rounds, then returns 0. A draw word (action 1) takes one round
// and then a bit-serial restoring remainder against s_limit; a zero limit
// returns 0 and leaves the state alone. All rounds and remainder steps go
// through one shared 33-bit adder. One word is in flight at a time; s_ready
// is high while idle, even when a result still waits on m_ready.

module rotate_add_prng_with_seeding_unit
    import rap_pkg::*;
(
    input  wire               aclk,
    input  wire               aresetn,
    input  wire               s_valid,
    output logic              s_ready,
    input  wire               s_action,
    input  wire [WordW-1:0]   s_seed_value,
    input  wire [WordW-1:0]   s_limit,
    output logic              m_valid,
    input  wire               m_ready,
    output logic [WordW-1:0]  m_value
);

    typedef enum logic [2:0] {
        ST_IDLE, ST_SEED_A, ST_SEED_B, ST_DRAW_A, ST_DRAW_B, ST_DIV, ST_DONE
    } state_t;

    state_t            state_reg, state_next;
    logic [WordW-1:0]  hi_reg, hi_next;
    logic [WordW-1:0]  lo_reg, lo_next;
    logic [WordW-1:0]  rem_reg, rem_next;
    logic [WordW-1:0]  div_reg, div_next;
    logic [WordW-1:0]  limit_reg, limit_next;
    logic [WordW-1:0]  res_reg, res_next;
    logic [CntW-1:0]   cnt_reg, cnt_next;
    logic              m_valid_reg, m_valid_next;
    logic [WordW-1:0]  m_value_reg, m_value_next;

    alu_req_t          alu_req;
    logic [AluW:0]     alu_sum;
    logic [AluW-1:0]   trial;
    logic [WordW-1:0]  rem_step;

    rap_alu u_alu (
        .req (alu_req),
        .sum (alu_sum)
    );

    assign s_ready = (state_reg == ST_IDLE);
    assign m_valid = m_valid_reg;
    assign m_value = m_value_reg;

    assign trial    = {rem_reg, div_reg[WordW-1]};
    assign rem_step = alu_sum[AluW] ? alu_sum[WordW-1:0] : trial[WordW-1:0];

    always_comb begin
        alu_req = '0;
        unique case (state_reg)
            ST_SEED_A, ST_DRAW_A: begin
                alu_req.a = {1'b0, rot16(hi_reg)};
                alu_req.b = {1'b0, lo_reg};
            end
            ST_SEED_B, ST_DRAW_B: begin
                alu_req.a = {1'b0, lo_reg};
                alu_req.b = {1'b0, hi_reg};
            end
            ST_DIV: begin
                // trial - limit as trial + ~limit + 1; carry out means no borrow
                alu_req.a   = trial;
                alu_req.b   = ~{1'b0, limit_reg};
                alu_req.cin = 1'b1;
            end
            default: alu_req = '0;
        endcase
    end

    always_comb begin
        state_next   = state_reg;
        hi_next      = hi_reg;
        lo_next      = lo_reg;
        rem_next     = rem_reg;
        div_next     = div_reg;
        limit_next   = limit_reg;
        res_next     = res_reg;
        cnt_next     = cnt_reg;
        m_valid_next = m_valid_reg;
        m_value_next = m_value_reg;

        if (m_valid_reg && m_ready) begin
            m_valid_next = 1'b0;
        end

        unique case (state_reg)
            ST_IDLE: begin
                if (s_valid) begin
                    cnt_next   = '0;
                    limit_next = s_limit;
                    res_next   = '0;
                    if (s_action == ActReseed) begin
                        if (s_seed_value == '0) begin
                            hi_next = ZeroSeedHigh;
                            lo_next = ZeroSeedLow;
                        end else begin
                            hi_next = s_seed_value ^ SeedMask;
                            lo_next = s_seed_value;
                        end
                        state_next = ST_SEED_A;
                    end else if (s_limit == '0) begin
                        state_next = ST_DONE;
                    end else begin
                        state_next = ST_DRAW_A;
                    end
                end
            end
            ST_SEED_A: begin
                hi_next    = alu_sum[WordW-1:0];
                state_next = ST_SEED_B;
            end
            ST_SEED_B: begin
                lo_next  = alu_sum[WordW-1:0];
                cnt_next = cnt_reg + 1'b1;
                if (cnt_reg == CntW'(Rounds - 1)) begin
                    state_next = ST_DONE;
                end else begin
                    state_next = ST_SEED_A;
                end
            end
            ST_DRAW_A: begin
                hi_next    = alu_sum[WordW-1:0];
                state_next = ST_DRAW_B;
            end
            ST_DRAW_B: begin
                lo_next    = alu_sum[WordW-1:0];
                div_next   = hi_reg;
                rem_next   = '0;
                cnt_next   = '0;
                state_next = ST_DIV;
            end
            ST_DIV: begin
                rem_next = rem_step;
                div_next = {div_reg[WordW-2:0], 1'b0};
                cnt_next = cnt_reg + 1'b1;
                if (cnt_reg == CntW'(WordW - 1)) begin
                    res_next   = rem_step;
                    state_next = ST_DONE;
                end
            end
            ST_DONE: begin
                if (!m_valid_reg || m_ready) begin
                    m_valid_next = 1'b1;
                    m_value_next = res_reg;
                    state_next   = ST_IDLE;
                end
            end
            default: state_next = ST_IDLE;
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg   <= ST_IDLE;
            hi_reg      <= WordW'(1);
            lo_reg      <= '0;
            cnt_reg     <= '0;
            m_valid_reg <= 1'b0;
        end else begin
            state_reg   <= state_next;
            hi_reg      <= hi_next;
            lo_reg      <= lo_next;
            cnt_reg     <= cnt_next;
            m_valid_reg <= m_valid_next;
        end
        rem_reg     <= rem_next;
        div_reg     <= div_next;
        limit_reg   <= limit_next;
        res_reg     <= res_next;
        m_value_reg <= m_value_next;
    end

    a_div_limit_nonzero: assert property (@(posedge aclk) disable iff (!aresetn)
        (state_reg == ST_DIV) |-> (limit_reg != '0))
        else $error("remainder running with zero limit");

    a_rem_below_limit: assert property (@(posedge aclk) disable iff (!aresetn)
        (state_reg == ST_DIV) |-> (rem_reg < limit_reg))
        else $error("partial remainder not below limit");

    a_state_held_in_div: assert property (@(posedge aclk) disable iff (!aresetn)
        (state_reg == ST_DIV) |=> ($stable(hi_reg) && $stable(lo_reg)))
        else $error("generator words changed during remainder");

    a_done_to_output: assert property (@(posedge aclk) disable iff (!aresetn)
        (state_reg == ST_DONE && (!m_valid_reg || m_ready)) |=> m_valid_reg)
        else $error("finished word not presented");

endmodule

`default_nettype wire

FILE: test/tb.sv
`default_nettype none

module tb;
    import rap_pkg::*;

    logic             aclk = 1'b0;
    logic             aresetn;
    logic             s_valid;
    logic             s_action;
    logic [WordW-1:0] s_seed_value;
    logic [WordW-1:0] s_limit;
    logic             m_ready;
    wire              s_ready;
    wire              m_valid;
    wire  [WordW-1:0] m_value;

    rotate_add_prng_with_seeding_unit uut (
        .aclk         (aclk),
        .aresetn      (aresetn),
        .s_valid      (s_valid),
        .s_ready      (s_ready),
        .s_action     (s_action),
        .s_seed_value (s_seed_value),
        .s_limit      (s_limit),
        .m_valid      (m_valid),
        .m_ready      (m_ready),
        .m_value      (m_value)
    );

    // generator state as the block should hold it
    logic [WordW-1:0] gen_hi = 32'd1;
    logic [WordW-1:0] gen_lo = 32'd0;
    logic [WordW-1:0] draw_q[$];
    logic [WordW-1:0] want;
    int               errors = 0;
    int               tx_idle_pct = 0;
    int               rx_idle_pct = 0;
    bit               hold_req = 1'b0;
    int               hold_left = 0;

    always begin
        #5 aclk = 1'b1;
        #5 aclk = 1'b0;
    end

    initial begin
        #10_000_000;
        $display("RESULT: ERROR");
        $finish;
    end

    function automatic logic [WordW-1:0] swap_halves(input logic [WordW-1:0] x);
        return {x[15:0], x[31:16]};
    endfunction

    task automatic advance_gen(input logic act, input logic [WordW-1:0] seed,
                               input logic [WordW-1:0] lim, output logic [WordW-1:0] res);
        logic [WordW-1:0] h;
        logic [WordW-1:0] acc;
        res = '0;
        if (act == ActReseed) begin
            if (seed == '0) begin
                h   = ZeroSeedHigh;
                acc = ZeroSeedLow;
            end else begin
                h   = seed ^ SeedMask;
                acc = seed;
            end
            for (int r = 0; r < Rounds; r++) begin
                h   = swap_halves(h) + acc;
                acc = acc + h;
            end
            gen_hi = h;
            gen_lo = acc;
        end else if (lim != '0) begin
            gen_hi = swap_halves(gen_hi) + gen_lo;
            gen_lo = gen_lo + gen_hi;
            res    = gen_hi % lim;
        end
    endtask

    task automatic send_word(input logic act, input logic [WordW-1:0] seed,
                             input logic [WordW-1:0] lim);
        logic [WordW-1:0] res;
        while ($urandom_range(99) < tx_idle_pct) begin
            s_valid <= 1'b0;
            @(posedge aclk);
        end
        s_valid      <= 1'b1;
        s_action     <= act;
        s_seed_value <= seed;
        s_limit      <= lim;
        do @(posedge aclk); while (!s_ready);
        advance_gen(act, seed, lim, res);
        draw_q.push_back(res);
    endtask

    // receiver: random idling, or a long hold when asked
    always @(posedge aclk) begin
        if (hold_req) begin
            hold_req  = 1'b0;
            hold_left = 600;
        end
        if (hold_left > 0) begin
            hold_left--;
            m_ready <= 1'b0;
        end else begin
            m_ready <= ($urandom_range(99) >= rx_idle_pct);
        end
    end

    always @(posedge aclk) begin
        if (aresetn && m_valid && m_ready) begin
            if (draw_q.size() == 0) begin
                $error("value: expected nothing, got %h", m_value);
                errors++;
            end else begin
                want = draw_q.pop_front();
                if (m_value !== want) begin
                    $error("value: expected %h, got %h", want, m_value);
                    errors++;
                end
            end
        end
    end

    function automatic logic [WordW-1:0] pick_limit();
        case ($urandom_range(9))
            0:       return '0;
            1, 2:    return $urandom_range(16, 1);
            3:       return 32'd1 << $urandom_range(31);
            4:       return ~($urandom_range(15));
            5:       return $urandom_range(32'hffff, 1);
            default: return $urandom;
        endcase
    endfunction

    function automatic logic [WordW-1:0] pick_seed();
        case ($urandom_range(9))
            0, 1:    return '0;
            2:       return $urandom_range(8);
            3:       return SeedMask ^ $urandom_range(3);
            default: return $urandom;
        endcase
    endfunction

    task automatic test_directed();
        send_word(ActDraw,   32'h0000_0000, 32'h0000_0000);
        send_word(ActDraw,   32'h0000_0000, 32'h0000_0001);
        send_word(ActDraw,   32'h0000_0000, 32'hffff_ffff);
        send_word(ActDraw,   32'hffff_ffff, 32'h8000_0000);
        send_word(ActDraw,   32'hffff_ffff, 32'h0000_0003);
        send_word(ActReseed, 32'h0000_0000, 32'hffff_ffff);
        send_word(ActDraw,   32'h0000_0000, 32'hffff_ffff);
        send_word(ActReseed, 32'hffff_ffff, 32'h0000_0000);
        send_word(ActDraw,   32'h0000_0000, 32'h0000_0007);
        send_word(ActReseed, SeedMask,      32'h0000_0005);
        send_word(ActDraw,   32'h1234_5678, 32'h0000_0000);
        send_word(ActDraw,   32'h0000_0000, 32'h0000_03e8);
        send_word(ActReseed, 32'h0000_0001, 32'h0000_0000);
        send_word(ActDraw,   32'h0000_0000, 32'h0000_0002);
        send_word(ActReseed, 32'h8000_0000, 32'h0000_0000);
        send_word(ActDraw,   32'h0000_0000, 32'hffff_fffe);
        send_word(ActDraw,   32'h0000_0000, 32'hffff_ffff);
        send_word(ActDraw,   32'h0000_0000, 32'h8000_0001);
    endtask

    task automatic test_random(input int n);
        for (int i = 0; i < n; i++) begin
            if ($urandom_range(9) == 0)
                send_word(ActReseed, pick_seed(), $urandom);
            else
                send_word(ActDraw, $urandom, pick_limit());
        end
    endtask

    // receiver holds off while words keep coming
    task automatic test_backpressure();
        tx_idle_pct = 0;
        hold_req    = 1'b1;
        test_random(24);
    endtask

    initial begin
        aresetn      = 1'b0;
        s_valid      = 1'b0;
        s_action     = 1'b0;
        s_seed_value = '0;
        s_limit      = '0;
        m_ready      = 1'b0;
        repeat (8) @(posedge aclk);
        aresetn <= 1'b1;
        @(posedge aclk);

        tx_idle_pct = 16;
        rx_idle_pct = 87;
        test_directed();
        test_random(500);

        tx_idle_pct = 87;
        rx_idle_pct = 16;
        test_random(500);

        rx_idle_pct = 0;
        test_backpressure();

        tx_idle_pct = 0;
        rx_idle_pct = 0;
        test_random(500);

        s_valid <= 1'b0;
        while (draw_q.size() != 0) @(posedge aclk);
        repeat (100) @(posedge aclk);
        if (errors == 0)
            $display("RESULT: OK");
        else
            $display("RESULT: ERROR");
        $finish;
    end

endmodule

`default_nettype wire
